// ===== rtl/core/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants of the cubic surface shading correction core.
// ----------------------------------------------------------------------------
package csc_pkg;

    // Field widths of the items.
    localparam int LUM_W      = 8;
    localparam int IN_COORD_W = 12;

    // Coordinate bits that take part in the surface.
    localparam int COORD_BITS = 12;
    localparam int CW         = COORD_BITS;

    // Configuration registers.
    localparam int COEF_W    = 64;
    localparam int NUM_COEFS = 7;
    localparam int CFG_IDX_W = 3;
    localparam logic [COEF_W-1:0] COEF_CONST_RESET = COEF_W'(255) << 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_CONST = 3'd0,
        CFG_COEF_Y1    = 3'd1,
        CFG_COEF_Y2    = 3'd2,
        CFG_COEF_Y3    = 3'd3,
        CFG_COEF_X1    = 3'd4,
        CFG_COEF_X2    = 3'd5,
        CFG_COEF_X3    = 3'd6
    } t_cfg_idx;

    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] t_coef_bank;

    // Power terms: row powers 1..3, then column powers 1..3.
    localparam int NUM_TERMS  = 6;
    localparam int TERM_SHIFT = 12;
    localparam int FRAC_W     = 16;

    // Datapath widths of the split multiplication.
    localparam int PW     = 3 * CW;
    localparam int PL     = (PW + 1) / 2;
    localparam int PH     = PW - PL;
    localparam int HALF_W = COEF_W / 2;
    localparam int LL_W   = HALF_W + PL;
    localparam int LH_W   = HALF_W + PH;
    localparam int HL_W   = HALF_W + PL + 1;
    localparam int HH_W   = HALF_W + PH + 1;
    localparam int LSW    = HALF_W + PW + 1;
    localparam int HSW    = HALF_W + PW + 2;
    localparam int PRW    = 2 * HALF_W + PW + 2;
    localparam int SW     = PRW + 4;

    // Upper clamp limit, 255 in Q16.
    localparam logic [SW-1:0] LIMIT_Q16 = SW'(255) << FRAC_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [LUM_W-1:0]      pixel_lum;
        logic [IN_COORD_W-1:0] col;
        logic [IN_COORD_W-1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [LUM_W-1:0] corrected_lum;
        logic             was_clipped;
    } t_out_item;

    // Item handed from the front to the back: luminance and coordinate powers.
    typedef struct packed {
        logic [LUM_W-1:0]               lum;
        logic [NUM_TERMS-1:0][PW-1:0]   pows;
    } t_pow_item;

endpackage

// ===== rtl/core/csc_front.sv =====
// ----------------------------------------------------------------------------
// csc_front
// Accepts pixels and forms the first, second and third powers of the row
// and column in a three stage pipeline, then hands them to the queue.
// ----------------------------------------------------------------------------
module csc_front
    import csc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_item  i_item,
    input  logic      i_q_full,
    output logic      o_q_push,
    output t_pow_item o_q_item
);

    logic              adv;
    logic              r_f0_valid, r_f1_valid, r_f2_valid;
    logic [LUM_W-1:0]  r_f0_lum, r_f1_lum, r_f2_lum;
    logic [CW-1:0]     r_f0_x, r_f0_y, r_f1_x, r_f1_y, r_f2_x, r_f2_y;
    logic [2*CW-1:0]   r_f1_x2, r_f1_y2, r_f2_x2, r_f2_y2;
    logic [3*CW-1:0]   r_f2_x3, r_f2_y3;
    logic [2*CW-1:0]   n_x2, n_y2;
    logic [3*CW-1:0]   n_x3, n_y3;

    // The whole front moves together; it holds only when its last stage
    // cannot be handed to a full queue.
    assign adv      = !(r_f2_valid && i_q_full);
    assign o_full   = !adv;
    assign o_q_push = r_f2_valid && !i_q_full;

    // Squares and cubes, one multiplication per stage.
    always_comb begin
        n_x2 = r_f0_x * r_f0_x;
        n_y2 = r_f0_y * r_f0_y;
        n_x3 = r_f1_x2 * r_f1_x;
        n_y3 = r_f1_y2 * r_f1_y;
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_valid <= 1'b0;
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (adv) begin
            r_f0_valid <= i_push;
            r_f1_valid <= r_f0_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    // Payload of the stages; the coordinates are taken at their full width.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f0_lum <= i_item.pixel_lum;
            r_f0_x   <= CW'(i_item.col);
            r_f0_y   <= CW'(i_item.row);
            r_f1_lum <= r_f0_lum;
            r_f1_x   <= r_f0_x;
            r_f1_y   <= r_f0_y;
            r_f1_x2  <= n_x2;
            r_f1_y2  <= n_y2;
            r_f2_lum <= r_f1_lum;
            r_f2_x   <= r_f1_x;
            r_f2_y   <= r_f1_y;
            r_f2_x2  <= r_f1_x2;
            r_f2_y2  <= r_f1_y2;
            r_f2_x3  <= n_x3;
            r_f2_y3  <= n_y3;
        end
    end

    // Pack the powers in term order: row powers first, then column powers.
    always_comb begin
        o_q_item.lum     = r_f2_lum;
        o_q_item.pows[0] = PW'(r_f2_y);
        o_q_item.pows[1] = PW'(r_f2_y2);
        o_q_item.pows[2] = PW'(r_f2_y3);
        o_q_item.pows[3] = PW'(r_f2_x);
        o_q_item.pows[4] = PW'(r_f2_x2);
        o_q_item.pows[5] = PW'(r_f2_x3);
    end

endmodule

// ===== rtl/core/csc_queue.sv =====
// ----------------------------------------------------------------------------
// csc_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csc_queue
    import csc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pow_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_pow_item o_item
);

    t_pow_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/csc_back.sv =====
// ----------------------------------------------------------------------------
// csc_back
// Evaluates the surface terms with split 32-bit partial products, sums them,
// subtracts the surface from the raised luminance and clamps the result.
// ----------------------------------------------------------------------------
module csc_back
    import csc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_coef_bank i_coefs,
    input  logic       i_q_empty,
    input  t_pow_item  i_q_item,
    output logic       o_q_pop,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_result
);

    typedef struct packed {
        logic [LL_W-1:0]        ll;
        logic [LH_W-1:0]        lh;
        logic signed [HL_W-1:0] hl;
        logic signed [HH_W-1:0] hh;
    } t_part;

    typedef struct packed {
        logic [LSW-1:0]        lo;
        logic signed [HSW-1:0] hi;
    } t_half;

    logic                  adv;
    logic                  r_b1_valid, r_b2_valid, r_b3_valid, r_b4_valid;
    logic                  r_b5_valid, r_b6_valid, r_b7_valid, r_out_valid;
    logic [LUM_W-1:0]      r_b1_lum, r_b2_lum, r_b3_lum, r_b4_lum, r_b5_lum, r_b6_lum;
    t_part                 r_part [NUM_TERMS];
    t_part                 n_part [NUM_TERMS];
    t_half                 r_half [NUM_TERMS];
    t_half                 n_half [NUM_TERMS];
    logic signed [SW-1:0]  r_term [NUM_TERMS];
    logic signed [SW-1:0]  n_term [NUM_TERMS];
    logic signed [SW-1:0]  r_s0, r_s1, r_s2, r_s3;
    logic signed [SW-1:0]  r_u0, r_u1;
    logic signed [SW-1:0]  r_surf;
    logic signed [SW-1:0]  r_val;
    logic signed [SW-1:0]  n_val;
    logic signed [SW-1:0]  const_term;
    t_out_item             r_out;
    t_out_item             n_out;

    // The back moves together whenever the output register is free or taken.
    assign adv      = !r_out_valid || pop;
    assign o_q_pop  = adv && !i_q_empty;
    assign empty    = !r_out_valid;
    assign o_result = r_out;

    // Stage 1: four partial products per term, each at most 32 by 19 bits.
    always_comb begin
        logic [COEF_W-1:0]        coef;
        logic [HALF_W-1:0]        cl;
        logic signed [HALF_W-1:0] ch;
        logic [PL-1:0]            pl;
        logic [PH-1:0]            ph;
        for (int k = 0; k < NUM_TERMS; k++) begin
            coef = i_coefs[k + 1];
            cl   = coef[HALF_W-1:0];
            ch   = $signed(coef[COEF_W-1:HALF_W]);
            pl   = i_q_item.pows[k][PL-1:0];
            ph   = i_q_item.pows[k][PW-1:PL];
            n_part[k].ll = cl * pl;
            n_part[k].lh = cl * ph;
            n_part[k].hl = ch * $signed({1'b0, pl});
            n_part[k].hh = ch * $signed({1'b0, ph});
        end
    end

    // Stage 2 joins the partials of each coefficient half, stage 3 forms the
    // full product and floors it to Q16 by its power's shift.
    always_comb begin
        logic signed [PRW-1:0] prod;
        int                    sh;
        for (int k = 0; k < NUM_TERMS; k++) begin
            n_half[k].lo = LSW'(r_part[k].ll) + (LSW'(r_part[k].lh) << PL);
            n_half[k].hi = HSW'(r_part[k].hl) + (HSW'(r_part[k].hh) <<< PL);
            prod = (PRW'(r_half[k].hi) << HALF_W) + PRW'(r_half[k].lo);
            sh   = TERM_SHIFT * ((k < 3) ? (k + 1) : (k - 2));
            n_term[k] = SW'(prod >>> sh);
        end
    end

    // Constant term and final difference against the raised luminance.
    always_comb begin
        logic [LUM_W:0] lum_up;
        const_term = SW'($signed(i_coefs[CFG_COEF_CONST]));
        lum_up     = (LUM_W + 1)'(r_b6_lum) + (LUM_W + 1)'(255);
        n_val      = $signed(SW'({lum_up, {FRAC_W{1'b0}}})) - r_surf;
    end

    // Clamp to 0..255 in Q16 and drop the fraction.
    always_comb begin
        if (r_val[SW-1]) begin
            n_out.corrected_lum = '0;
            n_out.was_clipped   = 1'b1;
        end else if (r_val > $signed(LIMIT_Q16)) begin
            n_out.corrected_lum = '1;
            n_out.was_clipped   = 1'b1;
        end else begin
            n_out.corrected_lum = r_val[FRAC_W +: LUM_W];
            n_out.was_clipped   = 1'b0;
        end
    end

    // Valid bits of the stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_b4_valid  <= 1'b0;
            r_b5_valid  <= 1'b0;
            r_b6_valid  <= 1'b0;
            r_b7_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_b1_valid  <= !i_q_empty;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_b4_valid  <= r_b3_valid;
            r_b5_valid  <= r_b4_valid;
            r_b6_valid  <= r_b5_valid;
            r_b7_valid  <= r_b6_valid;
            r_out_valid <= r_b7_valid;
        end
    end

    // Payload of the stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < NUM_TERMS; k++) begin
                r_part[k] <= n_part[k];
                r_half[k] <= n_half[k];
                r_term[k] <= n_term[k];
            end
            r_b1_lum <= i_q_item.lum;
            r_b2_lum <= r_b1_lum;
            r_b3_lum <= r_b2_lum;
            r_b4_lum <= r_b3_lum;
            r_b5_lum <= r_b4_lum;
            r_b6_lum <= r_b5_lum;
            // Adder tree over the constant and the six terms.
            r_s0     <= const_term + r_term[0];
            r_s1     <= r_term[1] + r_term[2];
            r_s2     <= r_term[3] + r_term[4];
            r_s3     <= r_term[5];
            r_u0     <= r_s0 + r_s1;
            r_u1     <= r_s2 + r_s3;
            r_surf   <= r_u0 + r_u1;
            r_val    <= n_val;
            r_out    <= n_out;
        end
    end

endmodule

// ===== rtl/core/cubic_surface_shading_correct_core.sv =====
// ----------------------------------------------------------------------------
// cubic_surface_shading_correct_core
// Corrects the luminance of each pixel against a separable cubic background
// surface of its row and column.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and gives one corrected pixel per clock
// for as long as results are popped. An item passes from push to the result
// port through three front stages that form the coordinate powers, the
// queue, seven back stages of split 32-bit partial products, adder tree
// and subtraction, and the output register. The rate of one item per clock
// is set by the fully pipelined partial product multipliers of the back.
// The user must write coefficients through the configuration port only while
// no item is in flight; the core does not enforce this. Index seven is ignored.
// ----------------------------------------------------------------------------
module cubic_surface_shading_correct_core
    import csc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_coef_bank r_coefs;
    logic       q_push, q_full, q_pop, q_empty;
    t_pow_item  q_in_item, q_out_item;

    // Coefficient registers; the constant term resets to 255 in Q16.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= t_coef_bank'({{((NUM_COEFS - 1) * COEF_W){1'b0}}, COEF_CONST_RESET});
        end else if (i_cfg_we && (i_cfg_idx <= CFG_COEF_X3)) begin
            r_coefs[i_cfg_idx] <= i_cfg_data;
        end
    end

    csc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_in_item)
    );

    csc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out_item)
    );

    csc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_coefs   (r_coefs),
        .i_q_empty (q_empty),
        .i_q_item  (q_out_item),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule
